### src/rtm_pkg.sv
// Shared types, register codes, constants and cos^2 table helpers for the transponder matcher.
package rtm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;

    localparam logic [CFG_IDX_W-1:0] REG_PRESENT_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_S       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_3A      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_C       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LATITUDE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LONGITUDE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ALTITUDE     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 3'd7;

    // present_mask bit positions
    localparam int PM_POSITION = 0;
    localparam int PM_ALTITUDE = 1;
    localparam int PM_MODE_S   = 2;
    localparam int PM_MODE_3A  = 3;
    localparam int PM_MODE_C   = 4;

    localparam int DIST_STAGES = 7;
    localparam int PIPE_STAGES = DIST_STAGES + 1;

    // meters per degree times degrees per half turn, over 32
    localparam int          METERS_PER_DEG = 111000;
    localparam int          HALF_TURN_DEG  = 180;
    localparam logic [19:0] DIST_SCALE     = 20'(HALF_TURN_DEG * METERS_PER_DEG / 32);

    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam longint unsigned HALF_PI_Q30 = PI_Q30 / 2;
    localparam longint          ONE_Q30     = 64'sd1 <<< 30;
    localparam longint unsigned TAYLOR_DIV [8] = '{2, 12, 30, 56, 90, 132, 182, 240};

    typedef struct packed {
        logic [4:0]         present_mask;
        logic [23:0]        mode_s;
        logic [11:0]        mode_3a;
        logic signed [13:0] mode_c_qfl;
        logic signed [25:0] latitude;
        logic signed [25:0] longitude;
        logic signed [17:0] altitude_ft;
        logic [15:0]        max_distance_m;
    } t_cfg;

    // cos(x), x and result Q30, x in [0, pi/2], truncating Taylor series
    function automatic longint cos_q30(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        sum  = ONE_Q30;
        for (int k = 0; k < 8; k++) begin
            term = (term * x2) >> 30;
            term = term / TAYLOR_DIV[k];
            if (k[0] == 1'b0) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        return sum;
    endfunction

    // 1 + cos(x) in Q16, saturated at 1.0 (2*cos^2(x/2) capped), from x in Q30 over [0, pi)
    function automatic logic [16:0] cos2_q16(input longint unsigned x);
        longint c;
        longint v;
        if (x > HALF_PI_Q30) begin
            c = -cos_q30(PI_Q30 - x);
        end else begin
            c = cos_q30(x);
        end
        v = (ONE_Q30 + c + 64'sd8192) >>> 14;
        if (v < 0) begin
            v = 0;
        end
        if (v > 65536) begin
            v = 65536;
        end
        return 17'(v);
    endfunction

endpackage

### src/reference_transponder_matcher.sv
// Top level of the reference transponder matcher: config registers, pipeline control, output.
//
// Takes one report per clock while o_ready is high and returns one result per report, in
// order. The pipeline depth is set by the distance pipeline: two squarings, the cos^2
// scaling and two constant multiplies by 624375 that replace the threshold division.
// Stages advance independently, so bubbles close up under output stall; o_ready falls
// only when every stage holds a request. The cos^2 table is a constant of COS_TABLE_DEPTH
// entries built at elaboration; there is no clearing pass after reset.
// Write configuration only while no request is in flight.
module reference_transponder_matcher
    import rtm_pkg::*;
#(
    parameter int COS_TABLE_DEPTH = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [25:0]     i_report_latitude,
    input  logic signed [25:0]     i_report_longitude,
    input  logic                   i_mode_s_valid,
    input  logic [23:0]            i_report_mode_s,
    input  logic                   i_skip_mode_s,
    input  logic                   i_mode_a_valid,
    input  logic [11:0]            i_report_mode_a,
    input  logic                   i_mode_c_valid,
    input  logic signed [13:0]     i_report_mode_c_qfl,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_matched,
    output logic signed [17:0]     o_match_altitude_ft,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PRESENT_MASK: r_cfg.present_mask   <= i_cfg_data[4:0];
                REG_MODE_S:       r_cfg.mode_s         <= i_cfg_data[23:0];
                REG_MODE_3A:      r_cfg.mode_3a        <= i_cfg_data[11:0];
                REG_MODE_C:       r_cfg.mode_c_qfl     <= i_cfg_data[13:0];
                REG_LATITUDE:     r_cfg.latitude       <= i_cfg_data[25:0];
                REG_LONGITUDE:    r_cfg.longitude      <= i_cfg_data[25:0];
                REG_ALTITUDE:     r_cfg.altitude_ft    <= i_cfg_data[17:0];
                REG_MAX_DISTANCE: r_cfg.max_distance_m <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // per-stage ready: a stage loads when empty or when the next one moves
    logic [PIPE_STAGES:0]   w_rdy;
    logic [PIPE_STAGES-1:0] r_v;

    always_comb begin
        w_rdy[PIPE_STAGES] = i_ready;
        for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < PIPE_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    logic w_id_ok;

    rtm_ident u_ident (
        .i_cfg               (r_cfg),
        .i_mode_s_valid      (i_mode_s_valid),
        .i_report_mode_s     (i_report_mode_s),
        .i_skip_mode_s       (i_skip_mode_s),
        .i_mode_a_valid      (i_mode_a_valid),
        .i_report_mode_a     (i_report_mode_a),
        .i_mode_c_valid      (i_mode_c_valid),
        .i_report_mode_c_qfl (i_report_mode_c_qfl),
        .o_id_ok             (w_id_ok)
    );

    logic w_far;

    rtm_dist #(
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_dist (
        .i_clk              (i_clk),
        .i_en               (w_rdy[DIST_STAGES-1:0]),
        .i_cfg              (r_cfg),
        .i_report_latitude  (i_report_latitude),
        .i_report_longitude (i_report_longitude),
        .o_far              (w_far)
    );

    // identity result travels alongside the distance pipeline
    logic [DIST_STAGES-1:0] r_ok;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_ok[0] <= w_id_ok;
        end
        for (int k = 1; k < DIST_STAGES; k++) begin
            if (w_rdy[k]) begin
                r_ok[k] <= r_ok[k-1];
            end
        end
    end

    logic               n_matched, r_matched;
    logic signed [17:0] n_alt, r_alt;

    always_comb begin
        n_matched = r_ok[DIST_STAGES-1] && !(r_cfg.present_mask[PM_POSITION] && w_far);
        n_alt     = (n_matched && r_cfg.present_mask[PM_ALTITUDE]) ? r_cfg.altitude_ft : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[PIPE_STAGES-1]) begin
            r_matched <= n_matched;
            r_alt     <= n_alt;
        end
    end

    assign o_valid             = r_v[PIPE_STAGES-1];
    assign o_matched           = r_matched;
    assign o_match_altitude_ft = r_alt;

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> &r_v)
        else $error("input blocked with an empty stage");

    a_alt_zero_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_matched |-> o_match_altitude_ft == 18'sd0)
        else $error("altitude on a failed report");

    a_id_fail_kills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[DIST_STAGES-1] && !r_ok[DIST_STAGES-1] && w_rdy[PIPE_STAGES-1] |=> !o_matched)
        else $error("match without identity");

endmodule

### src/rtm_ident.sv
// Identity checks of a report against the reference: Mode S, Mode 3/A, Mode C.
module rtm_ident
    import rtm_pkg::*;
(
    input  t_cfg               i_cfg,
    input  logic               i_mode_s_valid,
    input  logic [23:0]        i_report_mode_s,
    input  logic               i_skip_mode_s,
    input  logic               i_mode_a_valid,
    input  logic [11:0]        i_report_mode_a,
    input  logic               i_mode_c_valid,
    input  logic signed [13:0] i_report_mode_c_qfl,
    output logic               o_id_ok
);

    logic s_chk, a_chk, c_chk;
    logic s_eq, a_eq, c_eq;
    logic any_fail, any_hit;

    always_comb begin
        s_chk = !i_skip_mode_s && i_cfg.present_mask[PM_MODE_S] && i_mode_s_valid;
        a_chk = i_cfg.present_mask[PM_MODE_3A] && i_mode_a_valid;
        c_chk = i_cfg.present_mask[PM_MODE_C] && i_mode_c_valid;
        s_eq  = i_report_mode_s == i_cfg.mode_s;
        a_eq  = i_report_mode_a == i_cfg.mode_3a;
        c_eq  = i_report_mode_c_qfl == i_cfg.mode_c_qfl;
        any_fail = (s_chk && !s_eq) || (a_chk && !a_eq) || (c_chk && !c_eq);
        // Mode C confirms only; it cannot make a match on its own
        any_hit  = (s_chk && s_eq) || (a_chk && a_eq);
        o_id_ok  = !any_fail && any_hit;
    end

endmodule

### src/rtm_dist.sv
// Pipelined squared-distance test of the report position against the reference.
module rtm_dist
    import rtm_pkg::*;
#(
    parameter int COS_TABLE_DEPTH = 256
) (
    input  logic                   i_clk,
    input  logic [DIST_STAGES-1:0] i_en,
    input  t_cfg                   i_cfg,
    input  logic signed [25:0]     i_report_latitude,
    input  logic signed [25:0]     i_report_longitude,
    output logic                   o_far
);

    localparam int IW = (COS_TABLE_DEPTH > 1) ? $clog2(COS_TABLE_DEPTH) : 1;
    localparam int DW = $clog2(COS_TABLE_DEPTH + 1);
    localparam int PW = 26 + DW;
    localparam int QW = PW - 24;

    // cos^2 table over |latitude|, built at elaboration
    logic [16:0] w_cos2 [COS_TABLE_DEPTH];

    for (genvar g = 0; g < COS_TABLE_DEPTH; g++) begin : g_cos
        localparam longint unsigned XG = (64'(g) * PI_Q30) / COS_TABLE_DEPTH;
        assign w_cos2[g] = cos2_q16(XG);
    end

    // stage 0: differences, magnitudes, table index
    logic signed [26:0] w_dlat, w_dlon, w_adlat, w_adlon;
    logic [25:0]        w_alat;
    logic [PW-1:0]      w_iprod;
    logic [QW-1:0]      w_iq;
    logic [IW-1:0]      w_idx;

    always_comb begin
        w_dlat  = 27'(i_report_latitude) - 27'(i_cfg.latitude);
        w_dlon  = 27'(i_report_longitude) - 27'(i_cfg.longitude);
        w_adlat = w_dlat[26] ? -w_dlat : w_dlat;
        w_adlon = w_dlon[26] ? -w_dlon : w_dlon;
        w_alat  = 26'(i_report_latitude[25] ? -i_report_latitude : i_report_latitude);
        w_iprod = PW'(w_alat) * PW'(COS_TABLE_DEPTH);
        w_iq    = w_iprod[PW-1:24];
        if (w_iq >= QW'(COS_TABLE_DEPTH)) begin
            w_idx = IW'(COS_TABLE_DEPTH - 1);
        end else begin
            w_idx = w_iq[IW-1:0];
        end
    end

    logic [25:0]   r0_adl, r0_adn;
    logic [IW-1:0] r0_idx;
    logic [51:0]   r1_l, r1_a;
    logic [16:0]   r1_c2;
    logic [51:0]   r2_l;
    logic [52:0]   r2_phi;
    logic [16:0]   r2_plo;
    logic [52:0]   r3_d;
    logic [46:0]   r4_q0;
    logic [45:0]   r4_q1;
    logic [72:0]   r5_e;
    logic [44:0]   r6_g0;
    logic [43:0]   r6_g1, r6_g2;
    logic [31:0]   r6_m2;

    logic [32:0] w_plo_full;
    assign w_plo_full = 33'(r1_a[15:0]) * 33'(r1_c2);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_adl <= w_adlat[25:0];
            r0_adn <= w_adlon[25:0];
            r0_idx <= w_idx;
        end
        if (i_en[1]) begin
            r1_l  <= 52'(r0_adl) * 52'(r0_adl);
            r1_a  <= 52'(r0_adn) * 52'(r0_adn);
            r1_c2 <= w_cos2[r0_idx];
        end
        if (i_en[2]) begin
            r2_l   <= r1_l;
            r2_phi <= 53'(r1_a[51:16]) * 53'(r1_c2);
            r2_plo <= w_plo_full[32:16];
        end
        if (i_en[3]) begin
            r3_d <= 53'(r2_l) + r2_phi + 53'(r2_plo);
        end
        // D * 624375^2 in two constant passes, split into partial products
        if (i_en[4]) begin
            r4_q0 <= 47'(r3_d[26:0]) * 47'(DIST_SCALE);
            r4_q1 <= 46'(r3_d[52:27]) * 46'(DIST_SCALE);
        end
        if (i_en[5]) begin
            r5_e <= 73'(r4_q0) + (73'(r4_q1) << 27);
        end
        if (i_en[6]) begin
            r6_g0 <= 45'(r5_e[24:0]) * 45'(DIST_SCALE);
            r6_g1 <= 44'(r5_e[48:25]) * 44'(DIST_SCALE);
            r6_g2 <= 44'(r5_e[72:49]) * 44'(DIST_SCALE);
            r6_m2 <= 32'(i_cfg.max_distance_m) * 32'(i_cfg.max_distance_m);
        end
    end

    logic [92:0] w_f, w_lim;

    always_comb begin
        w_f   = 93'(r6_g0) + (93'(r6_g1) << 25) + (93'(r6_g2) << 49);
        w_lim = 93'(r6_m2) << 40;
        o_far = w_f > w_lim;
    end

endmodule

### dv/rtm_match_checker.sv
// Checker for the transponder matcher: predicts each verdict and compares it in order.
`timescale 1ns / 100ps

module rtm_match_checker
    import rtm_pkg::*;
#(
    parameter int COS_DEPTH = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic signed [25:0]    i_report_latitude,
    input  logic signed [25:0]    i_report_longitude,
    input  logic                  i_mode_s_valid,
    input  logic [23:0]           i_report_mode_s,
    input  logic                  i_skip_mode_s,
    input  logic                  i_mode_a_valid,
    input  logic [11:0]           i_report_mode_a,
    input  logic                  i_mode_c_valid,
    input  logic signed [13:0]    i_report_mode_c_qfl,
    input  logic                  i_rsp_valid,
    input  logic                  i_rsp_ready,
    input  logic                  i_matched,
    input  logic signed [17:0]    i_match_altitude_ft,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_outstanding,
    output int                    o_error_count
);

    localparam longint unsigned RANGE_SCALE = 64'd624375;

    typedef struct packed {
        logic               matched;
        logic signed [17:0] altitude_ft;
    } t_verdict;

    t_cfg            ref_cfg;
    t_verdict        expected_verdicts[$];
    longint unsigned cos_sq_tab[COS_DEPTH];
    int              error_total = 0;

    function automatic longint taylor_cos(input longint unsigned ang);
        longint unsigned ang_sq;
        longint unsigned term;
        longint          acc;
        ang_sq = (ang * ang) >> 30;
        term   = 64'd1 << 30;
        acc    = 64'sd1 <<< 30;
        for (int k = 1; k <= 8; k++) begin
            term = (term * ang_sq) >> 30;
            term = term / longint'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        return acc;
    endfunction

    initial begin
        longint unsigned ang;
        longint          c;
        longint          v;
        for (int i = 0; i < COS_DEPTH; i++) begin
            ang = longint'(i) * PI_Q30 / COS_DEPTH;
            if (ang > PI_Q30 / 2) begin
                c = -taylor_cos(PI_Q30 - ang);
            end else begin
                c = taylor_cos(ang);
            end
            v = ((64'sd1 <<< 30) + c + 64'sd8192) >>> 14;
            if (v < 0) begin
                v = 0;
            end
            if (v > 65536) begin
                v = 65536;
            end
            cos_sq_tab[i] = v;
        end
    end

    // squared range limit in angle units^2
    function automatic longint unsigned range_limit_sq(input logic [15:0] max_m);
        logic [127:0] num;
        num = 128'(max_m) * 128'(max_m);
        num = num << 40;
        return 64'(num / (128'(RANGE_SCALE) * 128'(RANGE_SCALE)));
    endfunction

    function automatic t_verdict predict_verdict();
        t_verdict        v;
        logic            id_hit;
        logic            pass;
        longint          lat_rep;
        longint          dlat;
        longint          dlon;
        longint unsigned alat;
        longint unsigned adlat;
        longint unsigned adlon;
        longint unsigned sq_lon;
        longint unsigned row;
        longint unsigned c2;
        longint unsigned dist_sq;
        id_hit = 1'b0;
        pass   = 1'b1;
        if (!i_skip_mode_s && ref_cfg.present_mask[PM_MODE_S] && i_mode_s_valid) begin
            if (i_report_mode_s != ref_cfg.mode_s) pass = 1'b0;
            else id_hit = 1'b1;
        end
        if (ref_cfg.present_mask[PM_MODE_3A] && i_mode_a_valid) begin
            if (i_report_mode_a != ref_cfg.mode_3a) pass = 1'b0;
            else id_hit = 1'b1;
        end
        if (ref_cfg.present_mask[PM_MODE_C] && i_mode_c_valid) begin
            if (i_report_mode_c_qfl != ref_cfg.mode_c_qfl) pass = 1'b0;
        end
        if (!id_hit) begin
            pass = 1'b0;
        end
        if (pass && ref_cfg.present_mask[PM_POSITION]) begin
            lat_rep = i_report_latitude;
            dlat    = lat_rep - longint'(ref_cfg.latitude);
            dlon    = longint'(i_report_longitude) - longint'(ref_cfg.longitude);
            alat    = (lat_rep < 0) ? -lat_rep : lat_rep;
            adlat   = (dlat < 0) ? -dlat : dlat;
            adlon   = (dlon < 0) ? -dlon : dlon;
            row     = (alat * COS_DEPTH) >> 24;
            // beyond 90 degrees the table row saturates
            if (row >= COS_DEPTH) begin
                row = longint'(COS_DEPTH - 1);
            end
            c2      = cos_sq_tab[row];
            sq_lon  = adlon * adlon;
            dist_sq = adlat * adlat + (sq_lon >> 16) * c2
                      + (((sq_lon & 64'hFFFF) * c2) >> 16);
            if (dist_sq > range_limit_sq(ref_cfg.max_distance_m)) begin
                pass = 1'b0;
            end
        end
        v.matched     = pass;
        v.altitude_ft = (pass && ref_cfg.present_mask[PM_ALTITUDE]) ? ref_cfg.altitude_ft : '0;
        return v;
    endfunction

    task automatic flag_error(input string what, input longint want, input longint got);
        error_total++;
        if (error_total <= 10) begin
            $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            ref_cfg = '0;
            expected_verdicts.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PRESENT_MASK: ref_cfg.present_mask   = i_cfg_data[4:0];
                    REG_MODE_S:       ref_cfg.mode_s         = i_cfg_data[23:0];
                    REG_MODE_3A:      ref_cfg.mode_3a        = i_cfg_data[11:0];
                    REG_MODE_C:       ref_cfg.mode_c_qfl     = i_cfg_data[13:0];
                    REG_LATITUDE:     ref_cfg.latitude       = i_cfg_data[25:0];
                    REG_LONGITUDE:    ref_cfg.longitude      = i_cfg_data[25:0];
                    REG_ALTITUDE:     ref_cfg.altitude_ft    = i_cfg_data[17:0];
                    REG_MAX_DISTANCE: ref_cfg.max_distance_m = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_verdicts.size() == 0) begin
                    flag_error("result with no request outstanding, matched", -1,
                               longint'(i_matched));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (i_matched !== want.matched) begin
                        flag_error("matched", longint'(want.matched), longint'(i_matched));
                    end
                    if (i_match_altitude_ft !== want.altitude_ft) begin
                        flag_error("match_altitude_ft", longint'(want.altitude_ft),
                                   longint'(i_match_altitude_ft));
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                expected_verdicts.push_back(predict_verdict());
            end
        end
        o_outstanding <= expected_verdicts.size();
        o_error_count <= error_total;
    end

endmodule

### dv/testbench.sv
// Testbench top for the transponder matcher: clock, reset, stimulus, flow control, verdict.
`timescale 1ns / 100ps

module testbench;
    import rtm_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int COS_DEPTH   = 256;
    localparam int HOLD_CYCLES = 150;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 215;

    typedef struct packed {
        logic signed [25:0] lat;
        logic signed [25:0] lon;
        logic               s_valid;
        logic [23:0]        mode_s;
        logic               skip_s;
        logic               a_valid;
        logic [11:0]        mode_a;
        logic               c_valid;
        logic signed [13:0] mode_c;
    } t_report;

    logic                  i_clk               = 1'b0;
    logic                  i_rst_n             = 1'b0;
    logic                  i_valid             = 1'b0;
    logic                  o_ready;
    logic signed [25:0]    i_report_latitude   = '0;
    logic signed [25:0]    i_report_longitude  = '0;
    logic                  i_mode_s_valid      = 1'b0;
    logic [23:0]           i_report_mode_s     = '0;
    logic                  i_skip_mode_s       = 1'b0;
    logic                  i_mode_a_valid      = 1'b0;
    logic [11:0]           i_report_mode_a     = '0;
    logic                  i_mode_c_valid      = 1'b0;
    logic signed [13:0]    i_report_mode_c_qfl = '0;
    logic                  o_valid;
    logic                  i_ready             = 1'b0;
    logic                  o_matched;
    logic signed [17:0]    o_match_altitude_ft;
    logic                  i_cfg_we            = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx           = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data          = '0;

    int   outstanding;
    int   error_count;
    int   hold_req     = 0;
    int   stall_cycles = 0;
    t_cfg cur_cfg      = '0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    reference_transponder_matcher #(
        .COS_TABLE_DEPTH(COS_DEPTH)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_report_latitude  (i_report_latitude),
        .i_report_longitude (i_report_longitude),
        .i_mode_s_valid     (i_mode_s_valid),
        .i_report_mode_s    (i_report_mode_s),
        .i_skip_mode_s      (i_skip_mode_s),
        .i_mode_a_valid     (i_mode_a_valid),
        .i_report_mode_a    (i_report_mode_a),
        .i_mode_c_valid     (i_mode_c_valid),
        .i_report_mode_c_qfl(i_report_mode_c_qfl),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_matched          (o_matched),
        .o_match_altitude_ft(o_match_altitude_ft),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data)
    );

    rtm_match_checker #(
        .COS_DEPTH(COS_DEPTH)
    ) u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req_valid        (i_valid),
        .i_req_ready        (o_ready),
        .i_report_latitude  (i_report_latitude),
        .i_report_longitude (i_report_longitude),
        .i_mode_s_valid     (i_mode_s_valid),
        .i_report_mode_s    (i_report_mode_s),
        .i_skip_mode_s      (i_skip_mode_s),
        .i_mode_a_valid     (i_mode_a_valid),
        .i_report_mode_a    (i_report_mode_a),
        .i_mode_c_valid     (i_mode_c_valid),
        .i_report_mode_c_qfl(i_report_mode_c_qfl),
        .i_rsp_valid        (o_valid),
        .i_rsp_ready        (i_ready),
        .i_matched          (o_matched),
        .i_match_altitude_ft(o_match_altitude_ft),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .o_outstanding      (outstanding),
        .o_error_count      (error_count)
    );

    task automatic push_report(input t_report r);
        i_valid             <= 1'b1;
        i_report_latitude   <= r.lat;
        i_report_longitude  <= r.lon;
        i_mode_s_valid      <= r.s_valid;
        i_report_mode_s     <= r.mode_s;
        i_skip_mode_s       <= r.skip_s;
        i_mode_a_valid      <= r.a_valid;
        i_report_mode_a     <= r.mode_a;
        i_mode_c_valid      <= r.c_valid;
        i_report_mode_c_qfl <= r.mode_c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // unused upper bits get random junk half the time
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int width,
                             input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] keep;
        logic [CFG_DATA_W-1:0] junk;
        keep       = (CFG_DATA_W'(1) << width) - CFG_DATA_W'(1);
        junk       = $urandom_range(1) ? CFG_DATA_W'($urandom) : '0;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= (value & keep) | (junk & ~keep);
        @(posedge i_clk);
    endtask

    task automatic apply_config(input t_cfg c);
        wait_idle();
        write_reg(REG_PRESENT_MASK, 5, CFG_DATA_W'(c.present_mask));
        write_reg(REG_MODE_S, 24, CFG_DATA_W'(c.mode_s));
        write_reg(REG_MODE_3A, 12, CFG_DATA_W'(c.mode_3a));
        write_reg(REG_MODE_C, 14, CFG_DATA_W'(c.mode_c_qfl));
        write_reg(REG_LATITUDE, 26, CFG_DATA_W'(c.latitude));
        write_reg(REG_LONGITUDE, 26, CFG_DATA_W'(c.longitude));
        write_reg(REG_ALTITUDE, 18, CFG_DATA_W'(c.altitude_ft));
        write_reg(REG_MAX_DISTANCE, 16, CFG_DATA_W'(c.max_distance_m));
        i_cfg_we <= 1'b0;
        cur_cfg = c;
    endtask

    function automatic t_cfg random_config();
        t_cfg c;
        c.present_mask = 5'($urandom);
        if ($urandom_range(3) != 0) begin
            c.present_mask[PM_MODE_S + $urandom_range(1)] = 1'b1;
        end
        c.mode_s      = 24'($urandom);
        c.mode_3a     = 12'($urandom);
        c.mode_c_qfl  = 14'($urandom);
        c.latitude    = $urandom_range(3) == 0 ? 26'($urandom)
                                               : 26'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
        c.longitude   = 26'($urandom);
        c.altitude_ft = 18'($urandom);
        case ($urandom_range(4))
            0:       c.max_distance_m = 16'd0;
            1:       c.max_distance_m = 16'hFFFF;
            2:       c.max_distance_m = 16'($urandom_range(100));
            default: c.max_distance_m = 16'($urandom);
        endcase
        return c;
    endfunction

    function automatic t_report matching_report();
        t_report r;
        r.lat     = cur_cfg.latitude;
        r.lon     = cur_cfg.longitude;
        r.s_valid = 1'b1;
        r.mode_s  = cur_cfg.mode_s;
        r.skip_s  = 1'b0;
        r.a_valid = 1'b1;
        r.mode_a  = cur_cfg.mode_3a;
        r.c_valid = 1'b1;
        r.mode_c  = cur_cfg.mode_c_qfl;
        return r;
    endfunction

    function automatic t_report random_report();
        t_report r;
        int      span;
        r         = matching_report();
        r.s_valid = $urandom_range(3) != 0;
        r.a_valid = $urandom_range(3) != 0;
        r.c_valid = $urandom_range(2) != 0;
        r.skip_s  = $urandom_range(7) == 0;
        if ($urandom_range(3) == 0) begin
            r.mode_s = $urandom_range(1) ? r.mode_s ^ (24'd1 << $urandom_range(23))
                                         : 24'($urandom);
        end
        if ($urandom_range(3) == 0) begin
            r.mode_a = $urandom_range(1) ? r.mode_a ^ (12'd1 << $urandom_range(11))
                                         : 12'($urandom);
        end
        if ($urandom_range(3) == 0) begin
            r.mode_c = $urandom_range(1) ? r.mode_c ^ (14'd1 << $urandom_range(13))
                                         : 14'($urandom);
        end
        // mostly near the reference, so the range check lands on both sides
        span = 2 * int'(cur_cfg.max_distance_m) + 8;
        case ($urandom_range(5))
            0: ;
            1: begin
                r.lat = 26'($urandom);
                r.lon = 26'($urandom);
            end
            default: begin
                r.lat = r.lat + 26'(int'($urandom_range(0, 2 * span)) - span);
                r.lon = r.lon + 26'(int'($urandom_range(0, 4 * span)) - 2 * span);
            end
        endcase
        return r;
    endfunction

    // receiver: its own stall pattern, plus a long hold-off on request
    initial begin
        int style;
        int stretch;
        int holds_seen;
        holds_seen = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req != holds_seen) begin
                holds_seen = hold_req;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            style   = $urandom_range(3);
            stretch = $urandom_range(1, 48);
            for (int n = 0; n < stretch; n++) begin
                case (style)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= 1'($urandom_range(1));
                    2:       i_ready <= ($urandom_range(3) == 0);
                    default: i_ready <= n[1];
                endcase
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_report r;
        t_cfg    c;
        int      sent;
        int      burst;
        int      gap;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        c                = '0;
        c.present_mask   = '1;
        c.mode_s         = 24'hABCDEF;
        c.mode_3a        = 12'o1234;
        c.mode_c_qfl     = 14'sd400;
        c.latitude       = 26'sd5000000;
        c.longitude      = -26'sd7000000;
        c.altitude_ft    = 18'sd130000;
        c.max_distance_m = 16'hFFFF;
        apply_config(c);
        push_report(matching_report());
        r = matching_report(); r.mode_s = r.mode_s ^ 24'd1;
        push_report(r);
        r.skip_s = 1'b1;
        push_report(r);
        r.a_valid = 1'b0;
        push_report(r);
        r = matching_report(); r.mode_c = r.mode_c + 14'sd1;
        push_report(r);
        r = matching_report(); r.c_valid = 1'b0; r.a_valid = 1'b0;
        push_report(r);
        r = matching_report(); r.s_valid = 1'b0; r.mode_a = ~r.mode_a;
        push_report(r);
        // latitude past the poles
        r = matching_report(); r.lat = 26'sh1FFFFFF;
        push_report(r);
        r.lat = 26'sh2000000; r.lon = 26'sh2000000;
        push_report(r);
        r = matching_report(); r.lon = 26'sh1FFFFFF;
        push_report(r);
        r = matching_report(); r.lat = r.lat + 26'sd100; r.lon = r.lon - 26'sd100;
        push_report(r);
        r = matching_report(); r.mode_s = '1; r.mode_a = '1; r.mode_c = 14'sh2000;
        push_report(r);
        r = matching_report(); r.c_valid = 1'b0; r.mode_c = 14'sh1FFF;
        push_report(r);

        c.present_mask = '0;
        c.present_mask[PM_POSITION] = 1'b1;
        c.present_mask[PM_MODE_S]   = 1'b1;
        c.latitude       = 26'sh1FFFFFF;
        c.altitude_ft    = -18'sd2000;
        c.max_distance_m = 16'd0;
        apply_config(c);
        push_report(matching_report());
        r = matching_report(); r.lon = r.lon + 26'sd1;
        push_report(r);
        r = matching_report(); r.lat = r.lat - 26'sd1;
        push_report(r);
        r = matching_report(); r.mode_s = ~r.mode_s;
        push_report(r);

        apply_config('0);
        push_report(matching_report());
        push_report(random_report());

        for (int p = 0; p < 8; p++) begin
            c = random_config();
            case (p)
                0: begin
                    c.present_mask   = '1;
                    c.max_distance_m = 16'hFFFF;
                    c.latitude       = 26'sd16777216;
                    c.longitude      = 26'sh1FFFFFF;
                    c.mode_c_qfl     = 14'sd5080;
                    c.altitude_ft    = 18'sd130000;
                    c.mode_s         = '1;
                end
                1: begin
                    c.max_distance_m = 16'd0;
                    c.present_mask[PM_POSITION] = 1'b1;
                end
                2: begin
                    c.present_mask = '1;
                    c.latitude     = -26'sd16777216;
                    c.longitude    = 26'sh2000000;
                    c.mode_c_qfl   = -14'sd48;
                    c.altitude_ft  = -18'sd2000;
                    c.mode_s       = '0;
                    c.mode_3a      = '0;
                end
                default: ;
            endcase
            apply_config(c);
            sent = 0;
            if (p == 2) begin
                // receiver holds off while requests keep coming
                hold_req <= hold_req + 1;
                repeat (120) push_report(random_report());
                sent = 120;
            end
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(1, 30);
                repeat (burst) push_report(random_report());
                sent += burst;
                gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
                if (gap != 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end

        wait_idle();
        repeat (3 * PIPE_STAGES) @(posedge i_clk);
        if (error_count == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### reference_transponder_matcher.f
src/rtm_pkg.sv
src/rtm_ident.sv
src/rtm_dist.sv
src/reference_transponder_matcher.sv
dv/rtm_match_checker.sv
dv/testbench.sv
